// ===== rtl/cat_pkg.sv =====
`default_nettype none
package cat_pkg;

  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_FULL   = 2'd2
  } stat_code_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic shift;
    logic fin;
  } cat_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad_idx;
    logic  shift_done;
  } cat_sts_t;

endpackage
`default_nettype wire

// ===== rtl/cat_ram.sv =====
`default_nettype none
module cat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cat_ctrl.sv =====
`default_nettype none
module cat_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire cat_pkg::cat_sts_t sts,
  output cat_pkg::cat_cmd_t      cmd
);
  import cat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd       = '0;
    cmd.take  = (state == S_IDLE) && s_tvalid && s_tready;
    cmd.exec  = (state == S_EXEC);
    cmd.shift = (state == S_SHIFT);
    cmd.fin   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.take) begin
            state    <= S_EXEC;
            s_tready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (sts.mode == MODE_REMOVE && !sts.bad_idx) begin
            state <= S_SHIFT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (sts.shift_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state    <= S_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready == (state == S_IDLE))
    else $error("ready out of step with idle state");

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == S_EXEC)
    else $error("accepted word did not start execution");

  a_shift_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !sts.shift_done) |=> state == S_SHIFT)
    else $error("compaction left early");
`endif

endmodule
`default_nettype wire

// ===== rtl/cat_dpath.sv =====
`default_nettype none
module cat_dpath #(
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [cat_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic      [cat_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire cat_pkg::cat_cmd_t                cmd,
  output cat_pkg::cat_sts_t                     sts
);
  import cat_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int PAD_W = OUT_TDATA_W - STATUS_W - VALUE_W - COUNT_W;

  mode_t               req_mode;
  logic [INDEX_W-1:0]  req_idx;
  logic [VALUE_W-1:0]  req_value;
  logic [CW-1:0]       count;
  stat_code_t          res_status;
  logic                res_rd;
  logic [CW-1:0]       sptr;
  logic [AW-1:0]       waddr_r;
  logic                pend;
  stat_code_t          out_status;
  logic [VALUE_W-1:0]  out_rd;
  logic [COUNT_W-1:0]  out_count;

  logic                full;
  logic                bad_idx;
  logic                rd_go;
  logic                shift_done;
  logic [CW-1:0]       sptr_dec;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  assign full       = (count == CW'(DEPTH));
  assign bad_idx    = (WW'(req_idx) >= WW'(count));
  assign rd_go      = (sptr < count);
  assign shift_done = !rd_go && !pend;
  assign sptr_dec   = sptr - CW'(1);

  assign sts.mode       = req_mode;
  assign sts.bad_idx    = bad_idx;
  assign sts.shift_done = shift_done;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(req_idx);
    ram_wdata = req_value;
    ram_re    = 1'b0;
    ram_raddr = AW'(req_idx);
    if (cmd.exec) begin
      case (req_mode)
        MODE_APPEND: begin
          ram_we    = !full;
          ram_waddr = count[AW-1:0];
        end
        MODE_READ: begin
          ram_re = !bad_idx;
        end
        MODE_WRITE: begin
          ram_we = !bad_idx;
        end
        default: begin
        end
      endcase
    end else if (cmd.shift) begin
      ram_we    = pend;
      ram_waddr = waddr_r;
      ram_wdata = ram_rdata;
      ram_re    = rd_go;
      ram_raddr = sptr[AW-1:0];
    end
  end

  cat_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_mode  <= mode_t'(s_tdata[MODE_W-1:0]);
      req_idx   <= s_tdata[MODE_W +: INDEX_W];
      req_value <= s_tdata[MODE_W+INDEX_W +: VALUE_W];
    end
    if (cmd.exec) begin
      res_rd     <= 1'b0;
      res_status <= ST_OK;
      sptr       <= CW'(req_idx) + CW'(1);
      if (req_mode == MODE_APPEND) begin
        if (full) begin
          res_status <= ST_FULL;
        end
      end else if (bad_idx) begin
        res_status <= ST_BADIDX;
      end else if (req_mode == MODE_READ) begin
        res_rd <= 1'b1;
      end
    end
    if (cmd.shift) begin
      waddr_r <= sptr_dec[AW-1:0];
      if (rd_go) begin
        sptr <= sptr + CW'(1);
      end
    end
    if (cmd.fin) begin
      out_status <= res_status;
      out_rd     <= res_rd ? ram_rdata : '0;
      out_count  <= COUNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pend <= 1'b0;
        if (req_mode == MODE_APPEND && !full) begin
          count <= count + CW'(1);
        end
      end else if (cmd.shift) begin
        pend <= rd_go;
        if (shift_done) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_count, out_rd, out_status};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (!cmd.exec && !cmd.shift) |=> $stable(count))
    else $error("entry count moved outside execution");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && pend && rd_go) |-> (CW'(waddr_r) < sptr))
    else $error("compaction write not below read");
`endif

endmodule
`default_nettype wire

// ===== rtl/compacting_array_table.sv =====
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: mode, index, value
// m_*       out  m_tvalid/m_tready  m_tdata: status, read_value, count
//
// One request at a time. Append, read, write and error cases go from
// accept through execute to result load.
// Remove adds a compaction walk: one entry is read from and one written
// back to the single store RAM per cycle.
// Reset clears the entry count and control state; store contents need no
// clearing. A stalled result holds in the output register; the next
// request is accepted while it waits and parks before its own result load.
module compacting_array_table #(
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [1:0] mode, [9:2] index, [41:10] value, [47:42] zero
  input  wire logic [cat_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [1:0] status, [33:2] read_value, [42:34] count, [47:43] zero
  output logic      [cat_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import cat_pkg::*;

  cat_cmd_t cmd;
  cat_sts_t sts;

  cat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cat_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .s_tdata(s_tdata),
    .m_tdata(m_tdata),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
`default_nettype wire
